// ===== design/owner_pending_class_bitmap_unit_macros.svh =====
// assertion macros for the owner pending class bitmap unit
`ifndef OWNER_PENDING_CLASS_BITMAP_UNIT_MACROS_SVH
`define OWNER_PENDING_CLASS_BITMAP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define OPCB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("opcb: implication violated");
// next-cycle implication
`define OPCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("opcb: next-cycle implication violated");
`else
`define OPCB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define OPCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/opcb_pkg.sv =====
`default_nettype none

package opcb_pkg;

  // request commands
  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_MISS  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // size fronts
  typedef enum logic [1:0] {
    FRONT_SMALL = 2'd0,
    FRONT_MID   = 2'd1,
    FRONT_LARGE = 2'd2,
    FRONT_NONE  = 2'd3
  } front_e;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  // bit layout of the visible word
  localparam int unsigned SMALL_SHIFT = 0;
  localparam int unsigned MID_SHIFT   = 16;
  localparam int unsigned LARGE_SHIFT = 32;
  localparam int unsigned SMALL_COUNT = 14;
  localparam int unsigned MID_COUNT   = 5;
  localparam int unsigned LARGE_COUNT = 4;
  localparam int unsigned WORD_BITS   = 36;

  // packed layout in the table: small, then mid, then large
  localparam int unsigned PACK_MID_BASE   = SMALL_COUNT;
  localparam int unsigned PACK_LARGE_BASE = SMALL_COUNT + MID_COUNT;
  localparam int unsigned PACK_BITS       = SMALL_COUNT + MID_COUNT + LARGE_COUNT;
  localparam int unsigned POS_BITS        = $clog2(PACK_BITS);

  // field widths
  localparam int unsigned SLOT_BITS    = 16;
  localparam int unsigned CLASS_BITS   = 6;
  localparam int unsigned CNT_SEL_BITS = 4;
  localparam int unsigned VALUE_BITS   = 32;

  // event counter indexes
  localparam int unsigned NUM_COUNTERS   = 9;
  localparam int unsigned CNT_PUB_SMALL  = 0;
  localparam int unsigned CNT_PUB_MID    = 1;
  localparam int unsigned CNT_PUB_LARGE  = 2;
  localparam int unsigned CNT_MISS_SMALL = 3;
  localparam int unsigned CNT_MISS_MID   = 4;
  localparam int unsigned CNT_MISS_LARGE = 5;
  localparam int unsigned CNT_MISS_ANY   = 6;
  localparam int unsigned CNT_MISS_TGT   = 7;
  localparam int unsigned CNT_MISS_OTHER = 8;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  // classified request
  typedef struct packed {
    cmd_e                    cmd;
    logic                    slot_ok;
    logic [SLOT_BITS-1:0]    slot;
    logic                    alive;
    logic                    class_ok;
    front_e                  front;
    logic [POS_BITS-1:0]     pos;
    logic                    sel_ok;
    logic [CNT_SEL_BITS-1:0] sel;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bk_status_t;

  // packed bitmap to visible word
  function automatic logic [WORD_BITS-1:0] expand_word(input logic [PACK_BITS-1:0] p);
    logic [WORD_BITS-1:0] w;
    w = '0;
    w[SMALL_SHIFT +: SMALL_COUNT] = p[0 +: SMALL_COUNT];
    w[MID_SHIFT +: MID_COUNT]     = p[PACK_MID_BASE +: MID_COUNT];
    w[LARGE_SHIFT +: LARGE_COUNT] = p[PACK_LARGE_BASE +: LARGE_COUNT];
    return w;
  endfunction

  // packed bits of one front's group
  function automatic logic [PACK_BITS-1:0] group_mask(input front_e f);
    logic [PACK_BITS-1:0] m;
    m = '0;
    case (f)
      FRONT_SMALL: m[0 +: SMALL_COUNT] = '1;
      FRONT_MID:   m[PACK_MID_BASE +: MID_COUNT] = '1;
      FRONT_LARGE: m[PACK_LARGE_BASE +: LARGE_COUNT] = '1;
      default:     m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/opcb_if.sv =====
`default_nettype none

// request channel
interface opcb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [15:0] owner_slot;
  logic       owner_alive;
  logic [1:0] front;
  logic [5:0] size_class;
  logic [3:0] counter_select;

  modport source (
    output valid, cmd, owner_slot, owner_alive, front, size_class, counter_select,
    input  ready
  );
  modport sink (
    input  valid, cmd, owner_slot, owner_alive, front, size_class, counter_select,
    output ready
  );
endinterface

// response channel
interface opcb_rsp_if;
  logic        valid;
  logic        ready;
  logic        applied;
  logic [35:0] pending_word;
  logic [31:0] counter_value;

  modport source (
    output valid, applied, pending_word, counter_value,
    input  ready
  );
  modport sink (
    input  valid, applied, pending_word, counter_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/opcb_ram.sv =====
`default_nettype none

module opcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/opcb_front.sv =====
`default_nettype none

module opcb_front #(
  parameter int unsigned OWNER_SLOTS = 65536
) (
  opcb_req_if.sink                  req_i,
  input  wire opcb_pkg::q_status_t  q_status_i,
  input  wire opcb_pkg::bk_status_t bk_status_i,
  output logic                      push_o,
  output opcb_pkg::item_t           item_o
);
  import opcb_pkg::*;

  logic [CLASS_BITS-1:0] cls;

  assign cls = req_i.size_class;

  // accept while the queue has room and the table is not being swept
  assign req_i.ready = !q_status_i.full && !bk_status_i.clearing;
  assign push_o      = req_i.valid && req_i.ready;

  // classify the request
  always_comb begin
    item_o         = '0;
    item_o.cmd     = cmd_e'(req_i.cmd);
    item_o.front   = front_e'(req_i.front);
    item_o.alive   = req_i.owner_alive;
    item_o.slot_ok = (req_i.owner_slot != '0) &&
                     ({1'b0, req_i.owner_slot} < (SLOT_BITS + 1)'(OWNER_SLOTS));
    item_o.slot    = item_o.slot_ok ? req_i.owner_slot : '0;
    item_o.sel_ok  = req_i.counter_select < CNT_SEL_BITS'(NUM_COUNTERS);
    item_o.sel     = item_o.sel_ok ? req_i.counter_select : '0;

    unique case (front_e'(req_i.front))
      FRONT_SMALL: begin
        item_o.class_ok = cls < CLASS_BITS'(SMALL_COUNT);
        item_o.pos      = POS_BITS'(cls);
      end
      FRONT_MID: begin
        item_o.class_ok = cls < CLASS_BITS'(MID_COUNT);
        item_o.pos      = POS_BITS'(cls) + POS_BITS'(PACK_MID_BASE);
      end
      FRONT_LARGE: begin
        item_o.class_ok = cls < CLASS_BITS'(LARGE_COUNT);
        item_o.pos      = POS_BITS'(cls) + POS_BITS'(PACK_LARGE_BASE);
      end
      FRONT_NONE: begin
        item_o.class_ok = 1'b0;
        item_o.pos      = '0;
      end
      default: begin
        item_o.class_ok = 1'b0;
        item_o.pos      = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/opcb_queue.sv =====
`default_nettype none

module opcb_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire opcb_pkg::item_t     item_i,
  input  wire logic                pop_i,
  output opcb_pkg::item_t          head_o,
  output opcb_pkg::q_status_t      status_o
);
  import opcb_pkg::*;

  item_t                 entries_q [QUEUE_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_BITS-1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.full  = count_q == Q_CNT_BITS'(QUEUE_DEPTH);
  assign status_o.empty = count_q == '0;

endmodule

`default_nettype wire

// ===== design/opcb_back.sv =====
`default_nettype none

module opcb_back #(
  parameter int unsigned OWNER_SLOTS  = 65536,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire opcb_pkg::item_t     head_i,
  input  wire opcb_pkg::q_status_t q_status_i,
  output logic                     pop_o,
  output opcb_pkg::bk_status_t     status_o,
  opcb_rsp_if.source               rsp_o
);
  import opcb_pkg::*;

  localparam int unsigned AW = $clog2(OWNER_SLOTS);

  bk_state_e state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [PACK_BITS-1:0] ram_wdata, ram_rdata;

  logic [COUNTER_BITS-1:0] cnt_q [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] inc;

  logic                  out_valid_q, out_valid_d;
  logic                  applied_q;
  logic [WORD_BITS-1:0]  word_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  commit;

  // execute datapath
  logic [PACK_BITS-1:0]  bitv, new_p;
  logic                  mark_ok, clr_ok, miss_ok, read_ok, write_ok;
  logic                  applied;
  logic [WORD_BITS-1:0]  word;
  logic [VALUE_BITS-1:0] value;
  logic [63:0]           cnt_wide;

  opcb_ram #(
    .WIDTH (PACK_BITS),
    .DEPTH (OWNER_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_i.slot[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // modify step on the bitmap that was just read
  always_comb begin
    bitv     = PACK_BITS'(1) << head_i.pos;
    mark_ok  = (head_i.cmd == CMD_MARK) && head_i.slot_ok && head_i.class_ok &&
               head_i.alive;
    clr_ok   = (head_i.cmd == CMD_CLEAR) && head_i.slot_ok && head_i.class_ok;
    miss_ok  = (head_i.cmd == CMD_MISS) && head_i.slot_ok && head_i.class_ok;
    read_ok  = (head_i.cmd == CMD_READ) && head_i.sel_ok;
    write_ok = mark_ok || clr_ok;
    applied  = mark_ok || clr_ok || miss_ok || read_ok;

    if (mark_ok) begin
      new_p = ram_rdata | bitv;
    end else if (clr_ok) begin
      new_p = ram_rdata & ~bitv;
    end else begin
      new_p = ram_rdata;
    end

    word     = head_i.slot_ok ? expand_word(new_p) : '0;
    cnt_wide = 64'(cnt_q[head_i.sel]);
    value    = read_ok ? cnt_wide[VALUE_BITS-1:0] : '0;
  end

  // event counter bumps for a committed request
  always_comb begin
    inc = '0;
    if (commit) begin
      unique case (head_i.front)
        FRONT_SMALL: begin
          inc[CNT_PUB_SMALL]  = mark_ok;
          inc[CNT_MISS_SMALL] = miss_ok;
        end
        FRONT_MID: begin
          inc[CNT_PUB_MID]  = mark_ok;
          inc[CNT_MISS_MID] = miss_ok;
        end
        FRONT_LARGE: begin
          inc[CNT_PUB_LARGE]  = mark_ok;
          inc[CNT_MISS_LARGE] = miss_ok;
        end
        FRONT_NONE: begin
        end
        default: begin
        end
      endcase
      inc[CNT_MISS_ANY]   = miss_ok && (ram_rdata != '0);
      inc[CNT_MISS_TGT]   = miss_ok && ram_rdata[head_i.pos];
      inc[CNT_MISS_OTHER] = miss_ok && ((ram_rdata & ~group_mask(head_i.front)) != '0);
    end
  end

  // sequencer: clearing sweep, read, then modify and write
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    ram_we     = 1'b0;
    ram_waddr  = head_i.slot[AW-1:0];
    ram_wdata  = new_p;
    ram_re     = 1'b0;
    pop_o      = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
        if (clr_addr_q == AW'(OWNER_SLOTS - 1)) begin
          state_d = BK_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          ram_re  = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_q || rsp_o.ready) begin
          commit  = 1'b1;
          ram_we  = write_ok;
          pop_o   = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // saturating event counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        if (inc[i] && (cnt_q[i] != '1)) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  // output register
  assign out_valid_d = commit ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      applied_q <= applied;
      word_q    <= word;
      value_q   <= value;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.applied       = applied_q;
  assign rsp_o.pending_word  = word_q;
  assign rsp_o.counter_value = value_q;

  assign status_o.clearing = state_q == BK_CLEAR;
  assign status_o.busy     = state_q == BK_EXEC;

endmodule

`default_nettype wire

// ===== design/owner_pending_class_bitmap_unit.sv =====
// channel  | dir | payload                                               | handshake
// req_i    | in  | cmd, owner_slot, owner_alive, front, size_class,      | valid/ready
//          |     | counter_select                                        |
// rsp_o    | out | applied, pending_word, counter_value                  | valid/ready
//
// in the back end each request gets one table read, then one modify and write;
// a new request is not started until the last one is written, and the write
// waits while an earlier result is still held on rsp_o. the result is registered.
// after reset the table is swept to zero, one slot a cycle, through all OWNER_SLOTS
// slots; req_i.ready stays low during the sweep.
// a two-entry queue keeps requests flowing in while a result waits on rsp_o.
`default_nettype none
`include "owner_pending_class_bitmap_unit_macros.svh"

module owner_pending_class_bitmap_unit #(
  parameter int unsigned OWNER_SLOTS  = 65536,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  opcb_req_if.sink   req_i,
  opcb_rsp_if.source rsp_o
);
  import opcb_pkg::*;

  item_t      push_item, head_item;
  logic       push, pop;
  q_status_t  q_status;
  bk_status_t bk_status;
  logic       bk_idle;
  logic       rsp_has_value;

  // classify incoming requests
  opcb_front #(
    .OWNER_SLOTS (OWNER_SLOTS)
  ) u_front (
    .req_i       (req_i),
    .q_status_i  (q_status),
    .bk_status_i (bk_status),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decoupling queue
  opcb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  // table and counters
  opcb_back #(
    .OWNER_SLOTS  (OWNER_SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_item),
    .q_status_i (q_status),
    .pop_o      (pop),
    .status_o   (bk_status),
    .rsp_o      (rsp_o)
  );

  // terms used by the checks
  assign bk_idle       = !bk_status.busy && !bk_status.clearing;
  assign rsp_has_value = rsp_o.valid && (rsp_o.counter_value != '0);

  // checks
  `OPCB_ASSERT_IMPLY(a_no_req_while_clearing, clk_i, rst_ni, bk_status.clearing, !req_i.ready)
  `OPCB_ASSERT_IMPLY(a_no_rsp_while_clearing, clk_i, rst_ni, bk_status.clearing, !rsp_o.valid)
  `OPCB_ASSERT_IMPLY(a_exec_has_head, clk_i, rst_ni, bk_status.busy, !q_status.empty)
  `OPCB_ASSERT_NEXT(a_idle_starts_work, clk_i, rst_ni, !q_status.empty && bk_idle, bk_status.busy)
  `OPCB_ASSERT_IMPLY(a_value_needs_applied, clk_i, rst_ni, rsp_has_value, rsp_o.applied)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import opcb_pkg::*;

  localparam int OWNER_SLOTS    = 65536;
  localparam int SEL_UNKNOWN    = 15;
  // sweep after reset covers all 65536 slots with no request taken
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int LONG_HOLD      = 80;
  localparam int TAIL_CYCLES    = 16;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] slot;
    logic        alive;
    front_e      front;
    logic [5:0]  cls;
    logic [3:0]  sel;
  } owner_req_t;

  typedef struct {
    logic        applied;
    logic [35:0] word;
    logic [31:0] value;
  } pend_result_t;

  logic clk_i;
  logic rst_ni;

  opcb_req_if req_if ();
  opcb_rsp_if rsp_if ();

  owner_pending_class_bitmap_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow of the pending bitmaps and event counters
  bit [35:0] pend_map [0:OWNER_SLOTS-1];
  bit [31:0] evt_count [NUM_COUNTERS];

  owner_req_t   pending_reqs [$];
  pend_result_t due_results [$];
  owner_req_t   drv_item;
  owner_req_t   taken_req;
  pend_result_t want;

  int  n_pushed;
  int  n_taken;
  int  n_checked;
  int  err_count;
  int  idle_cycles;
  int  src_idle_pct;
  int  snk_idle_pct;
  int  stall_requests;
  int  stall_served;
  int  hold_left;
  int  n_applied;
  int  n_by_cmd [4];
  logic req_fire;

  // saturating event counter
  function automatic void bump_event(int idx);
    if (evt_count[idx] != '1) evt_count[idx]++;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic pend_result_t apply_owner_request(owner_req_t r);
    pend_result_t res;
    bit           slot_ok;
    bit [35:0]    cbit;
    bit [35:0]    gmask;
    bit [35:0]    cur;
    res.applied = 1'b0;
    res.word    = '0;
    res.value   = '0;
    slot_ok = (r.slot != 0) && (int'(r.slot) < OWNER_SLOTS);
    cbit  = '0;
    gmask = '0;
    case (r.front)
      FRONT_SMALL: begin
        gmask = ((36'd1 << SMALL_COUNT) - 36'd1) << SMALL_SHIFT;
        if (r.cls < SMALL_COUNT) cbit = 36'd1 << (SMALL_SHIFT + r.cls);
      end
      FRONT_MID: begin
        gmask = ((36'd1 << MID_COUNT) - 36'd1) << MID_SHIFT;
        if (r.cls < MID_COUNT) cbit = 36'd1 << (MID_SHIFT + r.cls);
      end
      FRONT_LARGE: begin
        gmask = ((36'd1 << LARGE_COUNT) - 36'd1) << LARGE_SHIFT;
        if (r.cls < LARGE_COUNT) cbit = 36'd1 << (LARGE_SHIFT + r.cls);
      end
      default: ;
    endcase
    if (r.cmd == CMD_READ) begin
      if (r.sel < NUM_COUNTERS) begin
        res.applied = 1'b1;
        res.value   = evt_count[r.sel];
      end
    end else if (slot_ok && cbit != '0) begin
      cur = pend_map[r.slot];
      case (r.cmd)
        CMD_MARK: begin
          if (r.alive) begin
            pend_map[r.slot] = cur | cbit;
            bump_event(CNT_PUB_SMALL + int'(r.front));
            res.applied = 1'b1;
          end
        end
        CMD_CLEAR: begin
          pend_map[r.slot] = cur & ~cbit;
          res.applied = 1'b1;
        end
        default: begin
          bump_event(CNT_MISS_SMALL + int'(r.front));
          if (cur != '0) bump_event(CNT_MISS_ANY);
          if ((cur & cbit) != '0) bump_event(CNT_MISS_TGT);
          if ((cur & ~gmask) != '0) bump_event(CNT_MISS_OTHER);
          res.applied = 1'b1;
        end
      endcase
    end
    if (slot_ok) res.word = pend_map[r.slot];
    return res;
  endfunction

  function automatic owner_req_t mk_req(cmd_e c, int slot, bit alive, front_e f, int cls,
                                        int sel);
    owner_req_t r;
    r.cmd   = c;
    r.slot  = 16'(slot);
    r.alive = alive;
    r.front = f;
    r.cls   = 6'(cls);
    r.sel   = 4'(sel);
    return r;
  endfunction

  // mostly well-formed requests on a few busy slots, the rest noise
  function automatic owner_req_t random_owner_request();
    owner_req_t r;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 35) r.cmd = CMD_MARK;
    else if (pick < 55) r.cmd = CMD_CLEAR;
    else if (pick < 85) r.cmd = CMD_MISS;
    else r.cmd = CMD_READ;
    pick = $urandom_range(99);
    if (pick < 80) r.slot = 16'($urandom_range(6, 1));
    else if (pick < 85) r.slot = '0;
    else if (pick < 90) r.slot = 16'hFFFF;
    else r.slot = 16'($urandom);
    r.alive = ($urandom_range(99) < 85);
    r.front = ($urandom_range(99) < 92) ? front_e'($urandom_range(2)) : FRONT_NONE;
    if ($urandom_range(99) < 85) begin
      case (r.front)
        FRONT_SMALL: r.cls = 6'($urandom_range(SMALL_COUNT - 1));
        FRONT_MID:   r.cls = 6'($urandom_range(MID_COUNT - 1));
        FRONT_LARGE: r.cls = 6'($urandom_range(LARGE_COUNT - 1));
        default:     r.cls = 6'($urandom_range(63));
      endcase
    end else begin
      r.cls = 6'($urandom_range(63));
    end
    r.sel = ($urandom_range(99) < 80) ? 4'($urandom_range(NUM_COUNTERS - 1))
                                      : 4'($urandom_range(15));
    return r;
  endfunction

  task automatic push_req(owner_req_t r);
    pending_reqs.push_back(r);
    n_pushed++;
  endtask

  // sender holds back until every request has its result
  task automatic drain();
    while (!(n_taken == n_pushed && due_results.size() == 0)) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && !req_fire) begin
        // held until taken
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item = pending_reqs.pop_front();
        req_if.valid          <= 1'b1;
        req_if.cmd            <= drv_item.cmd;
        req_if.owner_slot     <= drv_item.slot;
        req_if.owner_alive    <= drv_item.alive;
        req_if.front          <= drv_item.front;
        req_if.size_class     <= drv_item.cls;
        req_if.counter_select <= drv_item.sel;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_served != stall_requests) begin
        stall_served  <= stall_requests;
        hold_left     <= LONG_HOLD;
        rsp_if.ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // monitor: predict on each request taken, check each result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire <= req_if.valid && req_if.ready;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;

      if (req_if.valid && req_if.ready) begin
        taken_req.cmd   = cmd_e'(req_if.cmd);
        taken_req.slot  = req_if.owner_slot;
        taken_req.alive = req_if.owner_alive;
        taken_req.front = front_e'(req_if.front);
        taken_req.cls   = req_if.size_class;
        taken_req.sel   = req_if.counter_select;
        want = apply_owner_request(taken_req);
        due_results.push_back(want);
        n_by_cmd[int'(taken_req.cmd)]++;
        if (want.applied) n_applied++;
        n_taken++;
      end

      if (rsp_if.valid && rsp_if.ready) begin
        n_checked++;
        if (due_results.size() == 0) begin
          $display("%0t: result with no request waiting: applied %0b word %h value %h",
                   $realtime, rsp_if.applied, rsp_if.pending_word, rsp_if.counter_value);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (rsp_if.applied !== want.applied) begin
            $display("%0t: applied mismatch: expected %0b actual %0b",
                     $realtime, want.applied, rsp_if.applied);
            err_count++;
          end
          if (rsp_if.pending_word !== want.word) begin
            $display("%0t: pending_word mismatch: expected %h actual %h",
                     $realtime, want.word, rsp_if.pending_word);
            err_count++;
          end
          if (rsp_if.counter_value !== want.value) begin
            $display("%0t: counter_value mismatch: expected %h actual %h",
                     $realtime, want.value, rsp_if.counter_value);
            err_count++;
          end
        end
      end
    end else begin
      req_fire    <= 1'b0;
      idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int read_sels [7];
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.cmd            = CMD_MARK;
    req_if.owner_slot     = '0;
    req_if.owner_alive    = 1'b0;
    req_if.front          = FRONT_SMALL;
    req_if.size_class     = '0;
    req_if.counter_select = '0;
    rsp_if.ready          = 1'b0;
    req_fire              = 1'b0;
    n_pushed = 0; n_taken = 0; n_checked = 0; err_count = 0; idle_cycles = 0;
    stall_requests = 0; stall_served = 0; hold_left = 0; n_applied = 0;
    n_by_cmd = '{default: 0};
    src_idle_pct = 31;
    snk_idle_pct = 47;
    read_sels = '{CNT_PUB_SMALL, CNT_MISS_SMALL, CNT_MISS_MID, CNT_MISS_ANY, CNT_MISS_TGT,
                  CNT_MISS_OTHER, SEL_UNKNOWN};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: group edges, bad class, bad slot, dead owner, miss flavours
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_SMALL, 0, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_SMALL, SMALL_COUNT - 1, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_MID, 0, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_MID, MID_COUNT - 1, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_LARGE, 0, 0));
    push_req(mk_req(CMD_MARK, 65535, 1, FRONT_LARGE, LARGE_COUNT - 1, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_SMALL, SMALL_COUNT, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_MID, MID_COUNT, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_LARGE, 63, 0));
    push_req(mk_req(CMD_MARK, 1, 1, FRONT_NONE, 0, 0));
    push_req(mk_req(CMD_MARK, 0, 1, FRONT_SMALL, 0, 0));
    push_req(mk_req(CMD_MARK, 2, 0, FRONT_SMALL, 3, 0));
    push_req(mk_req(CMD_MISS, 1, 1, FRONT_SMALL, 0, 0));
    push_req(mk_req(CMD_MISS, 2, 1, FRONT_MID, 2, 0));
    push_req(mk_req(CMD_MISS, 65535, 1, FRONT_SMALL, 1, 0));
    push_req(mk_req(CMD_CLEAR, 1, 0, FRONT_SMALL, 0, 0));
    push_req(mk_req(CMD_CLEAR, 1, 1, FRONT_MID, 9, 0));
    push_req(mk_req(CMD_MISS, 0, 1, FRONT_LARGE, 0, 0));
    push_req(mk_req(CMD_CLEAR, 65535, 1, FRONT_LARGE, LARGE_COUNT - 1, 0));
    foreach (read_sels[i]) push_req(mk_req(CMD_READ, (i == 6) ? 0 : 1, 1, FRONT_SMALL, 0,
                                           read_sels[i]));
    drain();

    // random, sender sparse and receiver slow
    src_idle_pct = 31;
    snk_idle_pct = 47;
    repeat (170) push_req(random_owner_request());
    drain();

    // random, roles swapped
    src_idle_pct = 47;
    snk_idle_pct = 31;
    repeat (170) push_req(random_owner_request());
    drain();

    // random at full rate, opening with a long receiver hold-off
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (160) push_req(random_owner_request());
    stall_requests++;
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("requests %0d (mark %0d clear %0d miss %0d read %0d), applied %0d",
             n_taken, n_by_cmd[0], n_by_cmd[1], n_by_cmd[2], n_by_cmd[3], n_applied);
    $display("results checked %0d, mismatches %0d", n_checked, err_count);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/opcb_pkg.sv
design/opcb_if.sv
design/opcb_ram.sv
design/opcb_front.sv
design/opcb_queue.sv
design/opcb_back.sv
design/owner_pending_class_bitmap_unit.sv
sim/testbench.sv
